FILE: design/a64_integer_alu_with_flags_core_macros.svh
// Assertion macros for the A64 integer ALU core.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef A64_INTEGER_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define A64_INTEGER_ALU_WITH_FLAGS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define A64ALU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define A64ALU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define A64ALU_ASSERT(label, clk, rstn, prop, msg)
`define A64ALU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/a64alu_pkg.sv
// Shared types and constants for the A64 integer ALU core.
// No dependencies.
`default_nettype none

package a64alu_pkg;

    localparam int DATA_W = 64;

    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_ADDS = 5'd1,
        ACT_SUB  = 5'd2,
        ACT_SUBS = 5'd3,
        ACT_AND  = 5'd4,
        ACT_ANDS = 5'd5,
        ACT_BIC  = 5'd6,
        ACT_BICS = 5'd7,
        ACT_ORR  = 5'd8,
        ACT_ORN  = 5'd9,
        ACT_EOR  = 5'd10,
        ACT_EON  = 5'd11,
        ACT_MOVN = 5'd12,
        ACT_MOVZ = 5'd13,
        ACT_MOVK = 5'd14,
        ACT_MADD = 5'd15,
        ACT_MSUB = 5'd16,
        ACT_LSL  = 5'd17,
        ACT_LSR  = 5'd18,
        ACT_ASR  = 5'd19,
        ACT_ROR  = 5'd20,
        ACT_COND = 5'd21
    } action_t;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // NZCV packed as N bit 3 down to V bit 0
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } nzcv_t;

    // Control produced by the execute stage for the accumulate stage
    typedef struct packed {
        nzcv_t flags_next;
        logic  flags_we;
        logic  taken;
        logic  mul_en;
        logic  mul_neg;
    } exec_ctrl_t;

endpackage

`default_nettype wire

FILE: design/a64alu_exec.sv
// Execute stage of the A64 integer ALU: all operations but the final
// multiply accumulate, plus the multiplier partial products. Uses a64alu_pkg.
`default_nettype none

module a64alu_exec #(
    parameter int DATA_WIDTH = a64alu_pkg::DATA_W
) (
    input  wire a64alu_pkg::action_t          action,
    input  wire                               wide_mode,
    input  wire [DATA_WIDTH-1:0]              operand_a,
    input  wire [DATA_WIDTH-1:0]              operand_b,
    input  wire [DATA_WIDTH-1:0]              operand_c,
    input  wire [$clog2(DATA_WIDTH)-1:0]      shift_count,
    input  wire [15:0]                        imm_half,
    input  wire [1:0]                         half_select,
    input  wire [3:0]                         cond_code,
    input  wire a64alu_pkg::nzcv_t            flags_cur,
    output logic [DATA_WIDTH-1:0]             result,
    output logic [DATA_WIDTH-1:0]             acc_masked,
    output logic [DATA_WIDTH-1:0]             prod_ll,
    output logic [DATA_WIDTH/2-1:0]           prod_lh,
    output logic [DATA_WIDTH/2-1:0]           prod_hl,
    output a64alu_pkg::exec_ctrl_t            ctrl
);

    localparam int HALF_W = DATA_WIDTH / 2;
    localparam int SH_W   = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0]   mask;
    logic [DATA_WIDTH-1:0]   a_m;
    logic [DATA_WIDTH-1:0]   b_m;
    logic [SH_W-1:0]         sh;
    logic [DATA_WIDTH:0]     sum;
    logic [DATA_WIDTH:0]     diff;
    logic [DATA_WIDTH-1:0]   sum_m;
    logic [DATA_WIDTH-1:0]   diff_m;
    logic [DATA_WIDTH-1:0]   asr_ext;
    logic [2*DATA_WIDTH-1:0] rot_dbl;
    logic [2*DATA_WIDTH-1:0] rot_sh;
    logic [DATA_WIDTH-1:0]   movk_val;
    logic [DATA_WIDTH-1:0]   r;
    logic [DATA_WIDTH-1:0]   full_lh;
    logic [DATA_WIDTH-1:0]   full_hl;
    logic                    cond_ok;
    logic                    ge;
    logic                    gt;

    function automatic logic top_bit(input logic [DATA_WIDTH-1:0] x, input logic w);
        top_bit = w ? x[DATA_WIDTH-1] : x[HALF_W-1];
    endfunction

    assign mask = wide_mode ? {DATA_WIDTH{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
    assign a_m  = operand_a & mask;
    assign b_m  = operand_b & mask;
    assign acc_masked = operand_c & mask;
    assign sh   = wide_mode ? shift_count : {1'b0, shift_count[SH_W-2:0]};

    assign sum    = {1'b0, a_m} + {1'b0, b_m};
    assign diff   = {1'b0, a_m} - {1'b0, b_m};
    assign sum_m  = sum[DATA_WIDTH-1:0] & mask;
    assign diff_m = diff[DATA_WIDTH-1:0] & mask;

    // 32-bit ASR: sign-extend the low word so the upper bits fill correctly
    assign asr_ext = wide_mode ? a_m : {{HALF_W{a_m[HALF_W-1]}}, a_m[HALF_W-1:0]};
    assign rot_dbl = wide_mode ? {a_m, a_m}
                               : {{DATA_WIDTH{1'b0}}, a_m[HALF_W-1:0], a_m[HALF_W-1:0]};
    assign rot_sh  = rot_dbl >> sh;

    always_comb begin
        movk_val = a_m;
        movk_val[{half_select, 4'b0000} +: 16] = imm_half;
    end

    // Low product split into half-width partial products
    assign prod_ll = a_m[HALF_W-1:0] * b_m[HALF_W-1:0];
    assign full_lh = a_m[HALF_W-1:0] * b_m[DATA_WIDTH-1:HALF_W];
    assign full_hl = a_m[DATA_WIDTH-1:HALF_W] * b_m[HALF_W-1:0];
    assign prod_lh = full_lh[HALF_W-1:0];
    assign prod_hl = full_hl[HALF_W-1:0];

    assign ge = (flags_cur.n == flags_cur.v);
    assign gt = !flags_cur.z && ge;

    always_comb begin
        case (cond_code)
            a64alu_pkg::COND_EQ: cond_ok = flags_cur.z;
            a64alu_pkg::COND_NE: cond_ok = !flags_cur.z;
            a64alu_pkg::COND_GE: cond_ok = ge;
            a64alu_pkg::COND_LT: cond_ok = !ge;
            a64alu_pkg::COND_GT: cond_ok = gt;
            a64alu_pkg::COND_LE: cond_ok = !gt;
            a64alu_pkg::COND_AL: cond_ok = 1'b1;
            default:             cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        r = '0;
        case (action)
            a64alu_pkg::ACT_ADD,
            a64alu_pkg::ACT_ADDS: r = sum[DATA_WIDTH-1:0];
            a64alu_pkg::ACT_SUB,
            a64alu_pkg::ACT_SUBS: r = diff[DATA_WIDTH-1:0];
            a64alu_pkg::ACT_AND,
            a64alu_pkg::ACT_ANDS: r = a_m & b_m;
            a64alu_pkg::ACT_BIC,
            a64alu_pkg::ACT_BICS: r = a_m & ~b_m;
            a64alu_pkg::ACT_ORR:  r = a_m | b_m;
            a64alu_pkg::ACT_ORN:  r = a_m | ~b_m;
            a64alu_pkg::ACT_EOR:  r = a_m ^ b_m;
            a64alu_pkg::ACT_EON:  r = a_m ^ ~b_m;
            a64alu_pkg::ACT_MOVN: r = ~b_m;
            a64alu_pkg::ACT_MOVZ: r = b_m;
            a64alu_pkg::ACT_MOVK: r = movk_val;
            a64alu_pkg::ACT_LSL:  r = a_m << sh;
            a64alu_pkg::ACT_LSR:  r = a_m >> sh;
            a64alu_pkg::ACT_ASR:  r = DATA_WIDTH'($signed(asr_ext) >>> sh);
            a64alu_pkg::ACT_ROR:  r = rot_sh[DATA_WIDTH-1:0];
            default:              r = '0;
        endcase
        result = r & mask;
    end

    always_comb begin
        ctrl            = '0;
        ctrl.flags_next = flags_cur;
        ctrl.flags_we   = action inside {a64alu_pkg::ACT_ADDS, a64alu_pkg::ACT_SUBS,
                                         a64alu_pkg::ACT_ANDS, a64alu_pkg::ACT_BICS};
        ctrl.taken      = (action == a64alu_pkg::ACT_COND) && cond_ok;
        ctrl.mul_en     = action inside {a64alu_pkg::ACT_MADD, a64alu_pkg::ACT_MSUB};
        ctrl.mul_neg    = (action == a64alu_pkg::ACT_MSUB);
        case (action)
            a64alu_pkg::ACT_ADDS: begin
                ctrl.flags_next.n = top_bit(sum_m, wide_mode);
                ctrl.flags_next.z = (sum_m == '0);
                ctrl.flags_next.c = wide_mode ? sum[DATA_WIDTH] : sum[HALF_W];
                ctrl.flags_next.v = top_bit((a_m ^ sum_m) & (b_m ^ sum_m), wide_mode);
            end
            a64alu_pkg::ACT_SUBS: begin
                ctrl.flags_next.n = top_bit(diff_m, wide_mode);
                ctrl.flags_next.z = (diff_m == '0);
                ctrl.flags_next.c = !diff[DATA_WIDTH];
                ctrl.flags_next.v = top_bit((a_m ^ b_m) & (a_m ^ diff_m), wide_mode);
            end
            a64alu_pkg::ACT_ANDS,
            a64alu_pkg::ACT_BICS: begin
                ctrl.flags_next.n = top_bit(result, wide_mode);
                ctrl.flags_next.z = (result == '0);
                ctrl.flags_next.c = 1'b0;
                ctrl.flags_next.v = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/a64_integer_alu_with_flags_core.sv
// A64 integer ALU with NZCV flags: top level, three-stage pipeline.
// Depends on a64alu_pkg, a64alu_exec and the assertion macro header.
//
// Usage:
//   Input channel s_* (valid/ready) carries one operation word: action,
//   width mode, three operands, shift count, MOVK immediate and lane, and a
//   condition code. Result channel m_* (valid/ready) returns the result,
//   the NZCV flags after that operation and the condition-check outcome.
//   The accepted word passes through the input register, the execute
//   register and the result register before it appears on m_*.
//   Throughput: one word per cycle while m_ready stays high. The multiply
//   is split into three half-width partial products in the execute stage
//   and summed with the accumulator in the second stage; the flags are
//   updated in the execute stage, so a condition check sees the flags left
//   by the flag-setting words before it.
//   Reset (aresetn low, synchronous) empties all stages and clears NZCV.
//   When the receiver holds m_ready low the result stays on m_*, the earlier
//   stages keep filling, and s_ready drops only once every stage is full.
`default_nettype none
`include "a64_integer_alu_with_flags_core_macros.svh"

module a64_integer_alu_with_flags_core #(
    parameter int DATA_WIDTH = a64alu_pkg::DATA_W
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [4:0]                    s_action,
    input  wire                          s_wide_mode,
    input  wire [DATA_WIDTH-1:0]         s_operand_a,
    input  wire [DATA_WIDTH-1:0]         s_operand_b,
    input  wire [DATA_WIDTH-1:0]         s_operand_c,
    input  wire [$clog2(DATA_WIDTH)-1:0] s_shift_count,
    input  wire [15:0]                   s_imm_half,
    input  wire [1:0]                    s_half_select,
    input  wire [3:0]                    s_cond_code,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [DATA_WIDTH-1:0]        m_result,
    output logic                         m_flag_n,
    output logic                         m_flag_z,
    output logic                         m_flag_c,
    output logic                         m_flag_v,
    output logic                         m_branch_taken
);

    localparam int HALF_W = DATA_WIDTH / 2;
    localparam int SH_W   = $clog2(DATA_WIDTH);

    // input stage
    logic                    in_valid_reg;
    logic [4:0]              in_action_reg;
    logic                    in_wide_reg;
    logic [DATA_WIDTH-1:0]   in_a_reg;
    logic [DATA_WIDTH-1:0]   in_b_reg;
    logic [DATA_WIDTH-1:0]   in_c_reg;
    logic [SH_W-1:0]         in_sh_reg;
    logic [15:0]             in_imm_reg;
    logic [1:0]              in_half_reg;
    logic [3:0]              in_cond_reg;

    // execute stage
    logic                    mid_valid_reg;
    logic [DATA_WIDTH-1:0]   mid_res_reg;
    logic [DATA_WIDTH-1:0]   mid_c_reg;
    logic [DATA_WIDTH-1:0]   mid_pll_reg;
    logic [HALF_W-1:0]       mid_plh_reg;
    logic [HALF_W-1:0]       mid_phl_reg;
    logic                    mid_wide_reg;
    a64alu_pkg::exec_ctrl_t  mid_ctrl_reg;

    // result stage
    logic                    out_valid_reg;
    logic [DATA_WIDTH-1:0]   out_result_reg;
    a64alu_pkg::nzcv_t       out_flags_reg;
    logic                    out_taken_reg;

    a64alu_pkg::nzcv_t       flag_reg;
    a64alu_pkg::nzcv_t       flag_next;

    logic                    out_ready;
    logic                    mid_ready;
    logic                    in_fire;
    logic                    mid_fire;

    logic [DATA_WIDTH-1:0]   ex_result;
    logic [DATA_WIDTH-1:0]   ex_acc;
    logic [DATA_WIDTH-1:0]   ex_pll;
    logic [HALF_W-1:0]       ex_plh;
    logic [HALF_W-1:0]       ex_phl;
    a64alu_pkg::exec_ctrl_t  ex_ctrl;

    logic [HALF_W-1:0]       cross_sum;
    logic [DATA_WIDTH-1:0]   product;
    logic [DATA_WIDTH-1:0]   acc_val;
    logic [DATA_WIDTH-1:0]   wmask;
    logic [DATA_WIDTH-1:0]   final_result;

    assign out_ready = m_ready || !out_valid_reg;
    assign mid_ready = out_ready || !mid_valid_reg;
    assign s_ready   = mid_ready || !in_valid_reg;
    assign in_fire   = in_valid_reg && mid_ready;
    assign mid_fire  = mid_valid_reg && out_ready;

    a64alu_exec #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_exec (
        .action      (a64alu_pkg::action_t'(in_action_reg)),
        .wide_mode   (in_wide_reg),
        .operand_a   (in_a_reg),
        .operand_b   (in_b_reg),
        .operand_c   (in_c_reg),
        .shift_count (in_sh_reg),
        .imm_half    (in_imm_reg),
        .half_select (in_half_reg),
        .cond_code   (in_cond_reg),
        .flags_cur   (flag_reg),
        .result      (ex_result),
        .acc_masked  (ex_acc),
        .prod_ll     (ex_pll),
        .prod_lh     (ex_plh),
        .prod_hl     (ex_phl),
        .ctrl        (ex_ctrl)
    );

    assign flag_next = (in_fire && ex_ctrl.flags_we) ? ex_ctrl.flags_next : flag_reg;

    // finish the product and accumulate
    assign cross_sum = mid_plh_reg + mid_phl_reg;
    assign product   = mid_pll_reg + {cross_sum, {HALF_W{1'b0}}};
    assign acc_val   = mid_ctrl_reg.mul_neg ? (mid_c_reg - product) : (mid_c_reg + product);
    assign wmask     = mid_wide_reg ? {DATA_WIDTH{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
    assign final_result = mid_ctrl_reg.mul_en ? (acc_val & wmask) : mid_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_ready) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_wide_reg   <= s_wide_mode;
            in_a_reg      <= s_operand_a;
            in_b_reg      <= s_operand_b;
            in_c_reg      <= s_operand_c;
            in_sh_reg     <= s_shift_count;
            in_imm_reg    <= s_imm_half;
            in_half_reg   <= s_half_select;
            in_cond_reg   <= s_cond_code;
        end
        if (in_fire) begin
            mid_res_reg  <= ex_result;
            mid_c_reg    <= ex_acc;
            mid_pll_reg  <= ex_pll;
            mid_plh_reg  <= ex_plh;
            mid_phl_reg  <= ex_phl;
            mid_wide_reg <= in_wide_reg;
            mid_ctrl_reg <= ex_ctrl;
        end
        if (mid_fire) begin
            out_result_reg <= final_result;
            out_flags_reg  <= mid_ctrl_reg.flags_next;
            out_taken_reg  <= mid_ctrl_reg.taken;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result       = out_result_reg;
    assign m_flag_n       = out_flags_reg.n;
    assign m_flag_z       = out_flags_reg.z;
    assign m_flag_c       = out_flags_reg.c;
    assign m_flag_v       = out_flags_reg.v;
    assign m_branch_taken = out_taken_reg;

    // a passing condition check never carries a result value
    `A64ALU_ASSERT(a_taken_zero, aclk, aresetn,
        !(m_valid && m_branch_taken) || (m_result == '0),
        "condition check word carries a non-zero result")
    // flags move only on a flag-setting word leaving the input stage
    `A64ALU_ASSERT_NEXT(a_flags_hold, aclk, aresetn,
        !(in_fire && ex_ctrl.flags_we), $stable(flag_reg),
        "flags changed without a flag-setting word")
    // a stalled execute stage must keep its word
    `A64ALU_ASSERT_NEXT(a_mid_hold, aclk, aresetn,
        mid_valid_reg && !out_ready, mid_valid_reg,
        "execute stage dropped a word under stall")

endmodule

`default_nettype wire

FILE: bench/a64_integer_alu_with_flags_core_tb.sv
// Self-checking bench for a64_integer_alu_with_flags_core: directed and random words
// against a behavioural ALU/NZCV predictor, with random idling on both channels.
// Depends on a64alu_pkg and the core RTL only.
`timescale 1ns / 1ps

module a64_integer_alu_with_flags_core_tb;

    localparam int          DATA_W        = a64alu_pkg::DATA_W;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          IDLE_PCT      = 35;
    localparam logic [4:0]  ACT_SPARE_MAX = 5'd31;
    localparam logic [63:0] LOW_WORD_MASK = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        logic [4:0]        action;
        logic              wide;
        logic [DATA_W-1:0] op_a;
        logic [DATA_W-1:0] op_b;
        logic [DATA_W-1:0] op_c;
        logic [5:0]        shamt;
        logic [15:0]       imm;
        logic [1:0]        lane;
        logic [3:0]        cond;
    } alu_word_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        a64alu_pkg::nzcv_t flags;
        logic              taken;
    } alu_outcome_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    wire               s_ready;
    logic [4:0]        s_action      = '0;
    logic              s_wide_mode   = 1'b0;
    logic [DATA_W-1:0] s_operand_a   = '0;
    logic [DATA_W-1:0] s_operand_b   = '0;
    logic [DATA_W-1:0] s_operand_c   = '0;
    logic [5:0]        s_shift_count = '0;
    logic [15:0]       s_imm_half    = '0;
    logic [1:0]        s_half_select = '0;
    logic [3:0]        s_cond_code   = '0;
    wire               m_valid;
    logic              m_ready       = 1'b0;
    wire  [DATA_W-1:0] m_result;
    wire               m_flag_n;
    wire               m_flag_z;
    wire               m_flag_c;
    wire               m_flag_v;
    wire               m_branch_taken;

    alu_outcome_t      pending_results[$];
    a64alu_pkg::nzcv_t model_flags = '0;
    int                mismatches  = 0;
    int                cycle_count = 0;
    logic              calm        = 1'b0;

    a64_integer_alu_with_flags_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_wide_mode   (s_wide_mode),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .s_operand_c   (s_operand_c),
        .s_shift_count (s_shift_count),
        .s_imm_half    (s_imm_half),
        .s_half_select (s_half_select),
        .s_cond_code   (s_cond_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_flag_n      (m_flag_n),
        .m_flag_z      (m_flag_z),
        .m_flag_c      (m_flag_c),
        .m_flag_v      (m_flag_v),
        .m_branch_taken(m_branch_taken)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Condition outcome on the flags held before this word
    function automatic logic condition_holds(input logic [3:0] code);
        logic ge;
        ge = (model_flags.n == model_flags.v);
        case (code)
            a64alu_pkg::COND_EQ: return model_flags.z;
            a64alu_pkg::COND_NE: return !model_flags.z;
            a64alu_pkg::COND_GE: return ge;
            a64alu_pkg::COND_LT: return !ge;
            a64alu_pkg::COND_GT: return !model_flags.z && ge;
            a64alu_pkg::COND_LE: return !(!model_flags.z && ge);
            a64alu_pkg::COND_AL: return 1'b1;
            default:             return 1'b0;
        endcase
    endfunction

    // Work out one word's outcome and advance the NZCV copy
    function automatic alu_outcome_t alu_execute(input alu_word_t w);
        logic [63:0]  mask;
        logic [63:0]  sgn;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  c;
        logic [63:0]  r;
        int unsigned  width;
        int unsigned  sh;
        int unsigned  pos;
        alu_outcome_t o;
        width   = w.wide ? 64 : 32;
        mask    = w.wide ? '1 : LOW_WORD_MASK;
        sgn     = 64'd1 << (width - 1);
        a       = w.op_a & mask;
        b       = w.op_b & mask;
        c       = w.op_c & mask;
        sh      = w.shamt & (width - 1);
        r       = '0;
        o.taken = 1'b0;
        case (w.action)
            a64alu_pkg::ACT_ADD:  r = a + b;
            a64alu_pkg::ACT_ADDS: begin
                r = (a + b) & mask;
                model_flags = '{n: (r & sgn) != 0, z: r == 0, c: r < a,
                                v: ((a ^ r) & (b ^ r) & sgn) != 0};
            end
            a64alu_pkg::ACT_SUB:  r = a - b;
            a64alu_pkg::ACT_SUBS: begin
                r = (a - b) & mask;
                model_flags = '{n: (r & sgn) != 0, z: r == 0, c: a >= b,
                                v: ((a ^ b) & (a ^ r) & sgn) != 0};
            end
            a64alu_pkg::ACT_AND:  r = a & b;
            a64alu_pkg::ACT_ANDS, a64alu_pkg::ACT_BICS: begin
                r = (w.action == a64alu_pkg::ACT_ANDS) ? (a & b) : (a & ~b & mask);
                model_flags = '{n: (r & sgn) != 0, z: r == 0, c: 1'b0, v: 1'b0};
            end
            a64alu_pkg::ACT_BIC:  r = a & ~b;
            a64alu_pkg::ACT_ORR:  r = a | b;
            a64alu_pkg::ACT_ORN:  r = a | ~b;
            a64alu_pkg::ACT_EOR:  r = a ^ b;
            a64alu_pkg::ACT_EON:  r = a ^ ~b;
            a64alu_pkg::ACT_MOVN: r = ~b;
            a64alu_pkg::ACT_MOVZ: r = b;
            a64alu_pkg::ACT_MOVK: begin
                // insert at full width, then cut: upper lanes vanish in 32-bit mode
                pos = w.lane * 16;
                r = (a & ~(64'hFFFF << pos)) | ({48'd0, w.imm} << pos);
            end
            a64alu_pkg::ACT_MADD: r = c + a * b;
            a64alu_pkg::ACT_MSUB: r = c - a * b;
            a64alu_pkg::ACT_LSL:  r = a << sh;
            a64alu_pkg::ACT_LSR:  r = a >> sh;
            a64alu_pkg::ACT_ASR: begin
                r = a >> sh;
                if ((a & sgn) != 0 && sh != 0)
                    r = r | (mask & ~(mask >> sh));
            end
            a64alu_pkg::ACT_ROR:  r = (sh == 0) ? a : ((a >> sh) | (a << (width - sh)));
            a64alu_pkg::ACT_COND: o.taken = condition_holds(w.cond);
            default:              r = '0;
        endcase
        o.value = r & mask;
        o.flags = model_flags;
        return o;
    endfunction

    // Offer one word, idle at random beforehand, log its outcome on acceptance
    task automatic send_word(input alu_word_t w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_action      <= w.action;
        s_wide_mode   <= w.wide;
        s_operand_a   <= w.op_a;
        s_operand_b   <= w.op_b;
        s_operand_c   <= w.op_c;
        s_shift_count <= w.shamt;
        s_imm_half    <= w.imm;
        s_half_select <= w.lane;
        s_cond_code   <= w.cond;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(alu_execute(w));
    endtask

    task automatic issue_word(input logic [4:0] action, input logic wide,
                              input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c = '0, input logic [5:0] sh = '0,
                              input logic [15:0] imm = '0, input logic [1:0] lane = '0,
                              input logic [3:0] cond = a64alu_pkg::COND_AL);
        alu_word_t w;
        w = '{action: action, wide: wide, op_a: a, op_b: b, op_c: c,
              shamt: sh, imm: imm, lane: lane, cond: cond};
        send_word(w);
    endtask

    // Hold the sender until every outstanding word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return 64'h0000_0000_8000_0000;
            5:       return LOW_WORD_MASK;
            6:       return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic alu_word_t random_word(input logic [4:0] action);
        alu_word_t w;
        w.action = action;
        w.wide   = 1'($urandom_range(1));
        w.op_a   = pick_operand();
        w.op_b   = ($urandom_range(7) == 0) ? w.op_a : pick_operand();
        w.op_c   = pick_operand();
        w.shamt  = 6'($urandom_range(63));
        w.imm    = 16'($urandom_range(16'hFFFF));
        w.lane   = 2'($urandom_range(3));
        w.cond   = 4'($urandom_range(15));
        return w;
    endfunction

    function automatic logic [4:0] pick_flag_op();
        case ($urandom_range(3))
            0:       return a64alu_pkg::ACT_ADDS;
            1:       return a64alu_pkg::ACT_SUBS;
            2:       return a64alu_pkg::ACT_ANDS;
            default: return a64alu_pkg::ACT_BICS;
        endcase
    endfunction

    // Flag setters chained with condition checks on the fresh flags, plus plain ADD and SUB
    task automatic test_add_sub_flags();
        issue_word(a64alu_pkg::ACT_ADDS, 1'b1, '1, 64'd1);
        issue_word(a64alu_pkg::ACT_COND, 1'b1, '0, '0, '0, '0, '0, '0, a64alu_pkg::COND_EQ);
        issue_word(a64alu_pkg::ACT_SUBS, 1'b0, 64'hFFFF_FFFF_8000_0000, 64'd1);
        issue_word(a64alu_pkg::ACT_COND, 1'b0, '0, '0, '0, '0, '0, '0, a64alu_pkg::COND_GE);
        issue_word(a64alu_pkg::ACT_ADD, 1'b1, '1, '1);
        issue_word(a64alu_pkg::ACT_SUB, 1'b0, 64'hFFFF_FFFF_0000_0000, 64'd1);
        issue_word(a64alu_pkg::ACT_SUBS, 1'b1, '0, '0);
        issue_word(a64alu_pkg::ACT_COND, 1'b1, '0, '0, '0, '0, '0, '0, a64alu_pkg::COND_LE);
        issue_word(a64alu_pkg::ACT_ADDS, 1'b0, LOW_WORD_MASK, 64'd1);
        issue_word(a64alu_pkg::ACT_COND, 1'b1, '0, '0, '0, '0, '0, '0, a64alu_pkg::COND_GT);
    endtask

    task automatic test_logic_and_moves();
        issue_word(a64alu_pkg::ACT_AND, 1'b1, '1, 64'h5555_5555_5555_5555);
        issue_word(a64alu_pkg::ACT_ANDS, 1'b1, 64'h8000_0000_0000_0001, '1);
        issue_word(a64alu_pkg::ACT_BIC, 1'b1, '1, 64'h00FF_00FF_00FF_00FF);
        issue_word(a64alu_pkg::ACT_BICS, 1'b0, 64'h1234_5678_9ABC_DEF0,
                   64'h1234_5678_9ABC_DEF0);
        issue_word(a64alu_pkg::ACT_ORR, 1'b1, 64'hF0F0_0000_0000_0000,
                   64'h0000_0000_0F0F_0F0F);
        issue_word(a64alu_pkg::ACT_ORN, 1'b0, '0, '0);
        issue_word(a64alu_pkg::ACT_EOR, 1'b1, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_word(a64alu_pkg::ACT_EON, 1'b1, '0, '0);
        issue_word(a64alu_pkg::ACT_MOVN, 1'b0, '1, '0);
        issue_word(a64alu_pkg::ACT_MOVZ, 1'b1, '0, '1);
        issue_word(a64alu_pkg::ACT_MOVK, 1'b1, '0, '0, '0, '0, 16'hFFFF, 2'd3);
    endtask

    task automatic test_mult_and_shifts();
        issue_word(a64alu_pkg::ACT_MADD, 1'b1, '1, '1, 64'h8000_0000_0000_0000);
        issue_word(a64alu_pkg::ACT_MSUB, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'd1);
        issue_word(a64alu_pkg::ACT_LSL, 1'b1, '1, '0, '0, 6'd63);
        issue_word(a64alu_pkg::ACT_LSR, 1'b0, '1, '0, '0, 6'd37);
        issue_word(a64alu_pkg::ACT_ASR, 1'b1, 64'h8000_0000_0000_0000, '0, '0, 6'd1);
        issue_word(a64alu_pkg::ACT_ROR, 1'b1, 64'h0000_0000_0000_0001, '0, '0, 6'd63);
    endtask

    // MOVK upper lane at 32 bits, rotate by zero, spare action and unlisted condition
    task automatic test_open_cases();
        issue_word(a64alu_pkg::ACT_MOVK, 1'b0, '1, '0, '0, '0, 16'h0000, 2'd2);
        issue_word(a64alu_pkg::ACT_ROR, 1'b0, 64'hDEAD_BEEF_8765_4321, '0, '0, 6'd32);
        issue_word(ACT_SPARE_MAX, 1'b1, '1, '1, '1, '1, '1, '1, a64alu_pkg::COND_AL);
        issue_word(a64alu_pkg::ACT_COND, 1'b1, '0, '0, '0, '0, '0, '0, 4'hF);
    endtask

    // Flag setter plus condition check pairs mixed with loose words and spare codes
    task automatic test_random_mix(input int count);
        int sent;
        int roll;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
                send_word(random_word(pick_flag_op()));
                send_word(random_word(a64alu_pkg::ACT_COND));
                sent += 2;
            end else begin
                if (roll < 43)
                    send_word(random_word(5'($urandom_range(ACT_SPARE_MAX,
                                                            a64alu_pkg::ACT_COND + 1))));
                else
                    send_word(random_word(5'($urandom_range(a64alu_pkg::ACT_COND))));
                sent++;
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        test_random_mix(count);
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        alu_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing outstanding, actual %h",
                         $time, m_result);
            end else begin
                want = pending_results.pop_front();
                check_field("result", want.value, m_result);
                check_field("flag_n", 64'(want.flags.n), 64'(m_flag_n));
                check_field("flag_z", 64'(want.flags.z), 64'(m_flag_z));
                check_field("flag_c", 64'(want.flags.c), 64'(m_flag_c));
                check_field("flag_v", 64'(want.flags.v), 64'(m_flag_v));
                check_field("branch_taken", 64'(want.taken), 64'(m_branch_taken));
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_add_sub_flags();
        test_logic_and_moves();
        test_mult_and_shifts();
        test_open_cases();
        test_random_mix(600);
        test_back_to_back(250);
        wait_drained();
        test_random_mix(400);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
